### sv/utl_pkg.sv
`timescale 1ns / 1ps

package utl_pkg;

	// Longest string the position and length counters track; both saturate here.
	localparam int MAX_URI_LEN = 4096;
	localparam int POS_W       = 13;
	localparam int TAG_W       = 4;
	localparam int SLOTS       = 3;
	localparam int CNT_W       = 2;

	localparam logic [TAG_W-1:0] TAG_UNKNOWN = 4'd0;
	localparam logic [TAG_W-1:0] TAG_EOS     = 4'd1;
	localparam logic [TAG_W-1:0] TAG_QMARK   = 4'd2;
	localparam logic [TAG_W-1:0] TAG_ASSIGN  = 4'd3;
	localparam logic [TAG_W-1:0] TAG_DELIM   = 4'd4;
	localparam logic [TAG_W-1:0] TAG_WORDY   = 4'd5;
	localparam logic [TAG_W-1:0] TAG_PATH    = 4'd6;
	localparam logic [TAG_W-1:0] TAG_INT     = 4'd7;
	localparam logic [TAG_W-1:0] TAG_ESC     = 4'd8;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_string;
	} item_t;

	typedef struct packed {
		logic [TAG_W-1:0] token_tag;
		logic [POS_W-1:0] token_start;
		logic [POS_W-1:0] token_length;
		logic [7:0]       decoded_byte;
		logic             last_token;
	} token_t;

	// All tokens caused by one input byte, oldest in slot 0.
	typedef struct packed {
		logic [CNT_W-1:0]         count;
		token_t [SLOTS-1:0]       tok;
	} bundle_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic    valid;
		bundle_t data;
	} head_t;

endpackage

### sv/uri_token_lexer.sv
`timescale 1ns / 1ps
// URI token lexer.
// Input channel: drive item (byte_in, end_of_string) with push; a request is
// taken at a rising edge with push high and full low. Mark the final byte of
// each URI with end_of_string.
// Result channel: while empty is low, result holds the oldest token (tag,
// start, length, decoded byte, last flag); raise pop to take it.
// Each byte yields zero to three tokens; the last byte of a string always
// yields at least the eos token, which carries last_token.
// A token caused by a taken request is written to the queue of token groups and
// then loaded into the result register.
// Throughput: one byte per cycle if pop is held and bytes yield at most one token each.
// The result register drains one token per cycle, so bytes that yield two or
// three tokens fill the four-entry queue of token groups and raise full until it drains.
// Reset: clears the lexer to idle at position zero and empties the queue and
// the result register; no clearing pass is needed.
// A stalled receiver holds the current result steady; the queue absorbs up
// to four more bytes' worth of tokens before full rises.
module uri_token_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  utl_pkg::item_t    item,
	input  logic              pop,
	output logic              empty,
	output utl_pkg::token_t   result
);

	logic              accept;
	logic              bundle_write;
	utl_pkg::bundle_t  bundle;
	utl_pkg::head_t    head;
	logic              deq;

	// Accept whenever the token queue has room.
	assign accept = push && !full;

	// Front: classify the byte, advance the run state, collect its tokens.
	utl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.bundle_write (bundle_write),
		.bundle       (bundle)
	);

	// Hold token groups between front and back.
	utl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (bundle_write),
		.wr_data (bundle),
		.rd      (deq),
		.head    (head),
		.full    (full)
	);

	// Back: move each group into the result register one token per cycle unless stalled.
	utl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.deq    (deq),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

### sv/utl_front.sv
`timescale 1ns / 1ps

module utl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  utl_pkg::item_t      item,
	output logic                bundle_write,
	output utl_pkg::bundle_t    bundle
);

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_TEXT = 5'b00010,
		M_INT  = 5'b00100,
		M_ESC1 = 5'b01000,
		M_ESC2 = 5'b10000
	} mode_t;

	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_ASSIGN  = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [utl_pkg::POS_W-1:0] POS_MAX = utl_pkg::POS_W'(utl_pkg::MAX_URI_LEN);
	localparam logic [utl_pkg::POS_W-1:0] LEN_ONE = utl_pkg::POS_W'(1);
	localparam logic [utl_pkg::POS_W-1:0] LEN_TWO = utl_pkg::POS_W'(2);
	localparam logic [utl_pkg::POS_W-1:0] LEN_ESC = utl_pkg::POS_W'(3);

	mode_t                       mode_q, mode_n;
	logic [utl_pkg::POS_W-1:0]   pos_q, pos_n;
	logic [utl_pkg::POS_W-1:0]   start_q, start_n;
	logic [utl_pkg::POS_W-1:0]   len_q, len_n;
	logic                        slash_q, slash_n;
	logic [3:0]                  hnib_q, hnib_n;

	logic [7:0]         c;
	logic               is_alpha, is_digit, is_hex, is_text;
	logic [3:0]         hex_val;
	logic               relex;
	utl_pkg::token_t    cand [4];
	logic [3:0]         cand_v;
	logic [2:0]         fill;

	function automatic logic [utl_pkg::POS_W-1:0] sat_inc(input logic [utl_pkg::POS_W-1:0] x);
		return (x < POS_MAX) ? x + LEN_ONE : x;
	endfunction

	function automatic utl_pkg::token_t mk(input logic [utl_pkg::TAG_W-1:0] tag,
			input logic [utl_pkg::POS_W-1:0] st, input logic [utl_pkg::POS_W-1:0] ln,
			input logic [7:0] dec, input logic lst);
		utl_pkg::token_t t;
		t.token_tag    = tag;
		t.token_start  = st;
		t.token_length = ln;
		t.decoded_byte = dec;
		t.last_token   = lst;
		return t;
	endfunction

	assign c        = item.byte_in;
	assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign is_text  = is_alpha || is_digit || c == CH_DOT || c == CH_SLASH;

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (is_digit) begin
			hex_val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hex_val = 4'(c - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		mode_n  = mode_q;
		start_n = start_q;
		len_n   = len_q;
		slash_n = slash_q;
		hnib_n  = hnib_q;
		relex   = 1'b0;
		for (int i = 0; i < 4; i++) begin
			cand[i] = '0;
		end
		cand_v  = '0;

		// Close or extend the open run.
		unique case (mode_q)
			M_TEXT: begin
				if (is_text) begin
					len_n = sat_inc(len_q);
					if (c == CH_SLASH) slash_n = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = mk(slash_q ? utl_pkg::TAG_PATH : utl_pkg::TAG_WORDY,
						start_q, len_q, 8'd0, 1'b0);
					relex     = 1'b1;
				end
			end
			M_INT: begin
				if (is_digit) begin
					len_n = sat_inc(len_q);
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = mk(utl_pkg::TAG_INT, start_q, len_q, 8'd0, 1'b0);
					relex     = 1'b1;
				end
			end
			M_ESC1: begin
				if (is_hex) begin
					hnib_n = hex_val;
					len_n  = LEN_TWO;
					mode_n = M_ESC2;
				end else begin
					cand_v[0] = 1'b1;
					cand[0]   = mk(utl_pkg::TAG_UNKNOWN, start_q, LEN_ESC, 8'd0, 1'b0);
					relex     = 1'b1;
				end
			end
			M_ESC2: begin
				cand_v[0] = 1'b1;
				if (is_hex) begin
					cand[0] = mk(utl_pkg::TAG_ESC, start_q, LEN_ESC, {hnib_q, hex_val}, 1'b0);
					mode_n  = M_IDLE;
				end else begin
					cand[0] = mk(utl_pkg::TAG_UNKNOWN, start_q, LEN_ESC, 8'd0, 1'b0);
					relex   = 1'b1;
				end
			end
			default: relex = 1'b1;
		endcase

		// Lex the byte from idle.
		if (relex) begin
			mode_n  = M_IDLE;
			slash_n = 1'b0;
			if (c == CH_QMARK) begin
				cand_v[1] = 1'b1;
				cand[1]   = mk(utl_pkg::TAG_QMARK, pos_q, LEN_ONE, 8'd0, 1'b0);
			end else if (c == CH_ASSIGN) begin
				cand_v[1] = 1'b1;
				cand[1]   = mk(utl_pkg::TAG_ASSIGN, pos_q, LEN_ONE, 8'd0, 1'b0);
			end else if (c == CH_AMP) begin
				cand_v[1] = 1'b1;
				cand[1]   = mk(utl_pkg::TAG_DELIM, pos_q, LEN_ONE, 8'd0, 1'b0);
			end else if (c == CH_PERCENT) begin
				mode_n  = M_ESC1;
				start_n = pos_q;
				len_n   = LEN_ONE;
			end else if (c == CH_SLASH || c == CH_DOT || is_alpha) begin
				mode_n  = M_TEXT;
				start_n = pos_q;
				len_n   = LEN_ONE;
				slash_n = (c == CH_SLASH);
			end else if (is_digit) begin
				mode_n  = M_INT;
				start_n = pos_q;
				len_n   = LEN_ONE;
			end else begin
				cand_v[1] = 1'b1;
				cand[1]   = mk(utl_pkg::TAG_UNKNOWN, pos_q, LEN_ONE, 8'd0, 1'b0);
			end
		end

		pos_n = sat_inc(pos_q);

		// End of string: flush the open run, append eos, drop all state.
		if (item.end_of_string) begin
			unique case (mode_n)
				M_TEXT: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk(slash_n ? utl_pkg::TAG_PATH : utl_pkg::TAG_WORDY,
						start_n, len_n, 8'd0, 1'b0);
				end
				M_INT: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk(utl_pkg::TAG_INT, start_n, len_n, 8'd0, 1'b0);
				end
				M_ESC1: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk(utl_pkg::TAG_UNKNOWN, start_n, LEN_ONE, 8'd0, 1'b0);
				end
				M_ESC2: begin
					cand_v[2] = 1'b1;
					cand[2]   = mk(utl_pkg::TAG_UNKNOWN, start_n, LEN_TWO, 8'd0, 1'b0);
				end
				default: ;
			endcase
			cand_v[3] = 1'b1;
			cand[3]   = mk(utl_pkg::TAG_EOS, pos_n, LEN_ONE, 8'd0, 1'b1);
			mode_n    = M_IDLE;
			pos_n     = '0;
			start_n   = '0;
			len_n     = '0;
			slash_n   = 1'b0;
			hnib_n    = '0;
		end
	end

	// Pack the candidates into consecutive slots, oldest first.
	always_comb begin
		bundle = '0;
		fill   = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && fill < 3'(utl_pkg::SLOTS)) begin
				bundle.tok[fill[1:0]] = cand[i];
				fill = fill + 3'd1;
			end
		end
		bundle.count = fill[utl_pkg::CNT_W-1:0];
	end

	assign bundle_write = accept && (fill != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			slash_q <= 1'b0;
			hnib_q  <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			len_q   <= len_n;
			slash_q <= slash_n;
			hnib_q  <= hnib_n;
		end
	end

endmodule

### sv/utl_queue.sv
`timescale 1ns / 1ps

module utl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  utl_pkg::bundle_t  wr_data,
	input  logic              rd,
	output utl_pkg::head_t    head,
	output logic              full
);

	localparam int DEPTH = 4;

	utl_pkg::bundle_t mem_q [DEPTH];
	logic [1:0]       wr_ptr_q, rd_ptr_q;
	logic [2:0]       cnt_q;
	logic             do_wr, do_rd;

	assign full       = (cnt_q == 3'(DEPTH));
	assign do_wr      = wr && !full;
	assign do_rd      = rd && (cnt_q != 3'd0);
	assign head.valid = (cnt_q != 3'd0);
	assign head.data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

endmodule

### sv/utl_back.sv
`timescale 1ns / 1ps

module utl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  utl_pkg::head_t    head,
	output logic              deq,
	input  logic              pop,
	output logic              empty,
	output utl_pkg::token_t   result
);

	logic [1:0]       idx_q;
	logic             out_v_q;
	utl_pkg::token_t  out_q;
	logic             load, slot_last;

	assign load      = head.valid && (!out_v_q || pop);
	assign slot_last = (idx_q == head.data.count - 2'd1);
	assign deq       = load && slot_last;
	assign empty     = !out_v_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (load) out_q <= head.data.tok[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= slot_last ? 2'd0 : idx_q + 2'd1;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

### sv/utl_checker.sv
`timescale 1ns / 1ps

module utl_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  utl_pkg::item_t    item,
	input  logic              pop,
	input  logic              empty,
	input  utl_pkg::token_t   result
);

	// A waiting token holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

	// The last flag appears only on a one-character eos token, and eos always has it.
	a_eos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.token_tag == utl_pkg::TAG_EOS) == result.last_token))
		else $error("eos tag and last flag disagree");

	a_eos_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.last_token) |-> (result.token_length == 13'd1))
		else $error("eos token length not one");

	// Only escaped-char tokens carry a decoded byte.
	a_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.token_tag != utl_pkg::TAG_ESC) |-> (result.decoded_byte == 8'd0))
		else $error("decoded byte on non-escape token");

endmodule

bind uri_token_lexer utl_checker u_checker (.*);

### tb/sv/tb_uri_token_lexer.sv
`timescale 1ns / 1ps

module tb_uri_token_lexer;

	// Lexer modes tracked by the predictor.
	typedef enum logic [4:0] {
		LX_IDLE = 5'b00001,
		LX_WORD = 5'b00010,
		LX_NUM  = 5'b00100,
		LX_PCT1 = 5'b01000,
		LX_PCT2 = 5'b10000
	} lex_mode_t;

	// One byte request plus, for hand-checked rows, the tokens it must yield.
	typedef struct packed {
		utl_pkg::item_t        it;
		logic                  typed;
		logic [1:0]            n;
		utl_pkg::token_t [2:0] toks;
	} row_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_ITEMS   = 380;
	localparam int CALM_TAIL      = 60;
	localparam int TAIL_CYCLES    = 10;

	logic            clk;
	logic            arst_n;
	logic            push;
	logic            full;
	utl_pkg::item_t  item;
	logic            pop;
	logic            empty;
	utl_pkg::token_t result;

	uri_token_lexer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	// Stimulus, tokens still owed by the block, and tokens of the latest byte.
	row_t            uri_bytes[$];
	utl_pkg::token_t tokens_due[$];
	utl_pkg::token_t fresh_tokens[$];

	int mismatches  = 0;
	int items_taken = 0;
	int hold_at     = 0;
	int pause_at    = 0;
	bit calm        = 1'b0;

	// Predictor state: mirrors the lexer's open run.
	lex_mode_t                 lx_mode   = LX_IDLE;
	logic [utl_pkg::POS_W-1:0] cur_pos   = '0;
	logic [utl_pkg::POS_W-1:0] tok_from  = '0;
	logic [utl_pkg::POS_W-1:0] tok_len   = '0;
	logic                      has_slash = 1'b0;
	logic [3:0]                hi_nib    = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [utl_pkg::POS_W-1:0] bump(input logic [utl_pkg::POS_W-1:0] x);
		return (x < utl_pkg::MAX_URI_LEN) ? x + 1'b1 : x;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Hex digit value, or -1 for anything else.
	function automatic int nib(input logic [7:0] c);
		if (is_num(c)) return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic utl_pkg::token_t tok(input logic [utl_pkg::TAG_W-1:0] tag,
			input logic [utl_pkg::POS_W-1:0] start,
			input logic [utl_pkg::POS_W-1:0] len, input logic [7:0] dec, input logic last);
		utl_pkg::token_t t;
		t.token_tag    = tag;
		t.token_start  = start;
		t.token_length = len;
		t.decoded_byte = dec;
		t.last_token   = last;
		return t;
	endfunction

	// Advance the predictor by one byte; leave its tokens in fresh_tokens.
	task automatic predict_tokens(input logic [7:0] c, input logic eos);
		int   v;
		logic relex;
		fresh_tokens.delete();
		relex = 1'b1;
		v = nib(c);
		case (lx_mode)
		LX_WORD: begin
			if (is_letter(c) || is_num(c) || c == "." || c == "/") begin
				tok_len = bump(tok_len);
				if (c == "/") has_slash = 1'b1;
				relex = 1'b0;
			end else begin
				fresh_tokens.push_back(tok(has_slash ? utl_pkg::TAG_PATH : utl_pkg::TAG_WORDY,
					tok_from, tok_len, 8'h00, 1'b0));
			end
		end
		LX_NUM: begin
			if (is_num(c)) begin
				tok_len = bump(tok_len);
				relex = 1'b0;
			end else begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_INT, tok_from, tok_len, 8'h00, 1'b0));
			end
		end
		LX_PCT1: begin
			if (v >= 0) begin
				hi_nib = v[3:0];
				tok_len = 13'd2;
				lx_mode = LX_PCT2;
				relex = 1'b0;
			end else begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_UNKNOWN, tok_from, 13'd3, 8'h00, 1'b0));
			end
		end
		LX_PCT2: begin
			if (v >= 0) begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_ESC, tok_from, 13'd3,
					{hi_nib, v[3:0]}, 1'b0));
				lx_mode = LX_IDLE;
				relex = 1'b0;
			end else begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_UNKNOWN, tok_from, 13'd3, 8'h00, 1'b0));
			end
		end
		default: ;
		endcase

		// Lex the byte from idle: either it could not extend the run, or no run was open.
		if (relex) begin
			lx_mode = LX_IDLE;
			has_slash = 1'b0;
			if (c == "?") begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_QMARK, cur_pos, 13'd1, 8'h00, 1'b0));
			end else if (c == "=") begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_ASSIGN, cur_pos, 13'd1, 8'h00, 1'b0));
			end else if (c == "&") begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_DELIM, cur_pos, 13'd1, 8'h00, 1'b0));
			end else if (c == "%") begin
				lx_mode = LX_PCT1;
				tok_from = cur_pos;
				tok_len = 13'd1;
			end else if (c == "/" || c == "." || is_letter(c)) begin
				lx_mode = LX_WORD;
				tok_from = cur_pos;
				tok_len = 13'd1;
				has_slash = (c == "/");
			end else if (is_num(c)) begin
				lx_mode = LX_NUM;
				tok_from = cur_pos;
				tok_len = 13'd1;
			end else begin
				fresh_tokens.push_back(tok(utl_pkg::TAG_UNKNOWN, cur_pos, 13'd1, 8'h00, 1'b0));
			end
		end
		cur_pos = bump(cur_pos);

		// Close whatever run is open, append eos, and start a new string.
		if (eos) begin
			case (lx_mode)
			LX_WORD: fresh_tokens.push_back(tok(has_slash ? utl_pkg::TAG_PATH : utl_pkg::TAG_WORDY,
				tok_from, tok_len, 8'h00, 1'b0));
			LX_NUM:  fresh_tokens.push_back(tok(utl_pkg::TAG_INT, tok_from, tok_len, 8'h00, 1'b0));
			LX_PCT1: fresh_tokens.push_back(tok(utl_pkg::TAG_UNKNOWN, tok_from, 13'd1, 8'h00, 1'b0));
			LX_PCT2: fresh_tokens.push_back(tok(utl_pkg::TAG_UNKNOWN, tok_from, 13'd2, 8'h00, 1'b0));
			default: ;
			endcase
			fresh_tokens.push_back(tok(utl_pkg::TAG_EOS, cur_pos, 13'd1, 8'h00, 1'b1));
			lx_mode = LX_IDLE;
			cur_pos = '0;
			tok_from = '0;
			tok_len = '0;
			has_slash = 1'b0;
			hi_nib = '0;
		end
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Compare one popped token against the oldest one owed, field by field.
	task automatic check_token(input utl_pkg::token_t got);
		utl_pkg::token_t want;
		if (tokens_due.size() == 0) begin
			note_mismatch($sformatf("token with nothing owed: tag %0d start %0d len %0d",
				got.token_tag, got.token_start, got.token_length));
			return;
		end
		want = tokens_due.pop_front();
		if (got.token_tag !== want.token_tag)
			note_mismatch($sformatf("tag %0d, want %0d (start %0d)",
				got.token_tag, want.token_tag, want.token_start));
		if (got.token_start !== want.token_start)
			note_mismatch($sformatf("start %0d, want %0d (tag %0d)",
				got.token_start, want.token_start, want.token_tag));
		if (got.token_length !== want.token_length)
			note_mismatch($sformatf("length %0d, want %0d (tag %0d start %0d)",
				got.token_length, want.token_length, want.token_tag, want.token_start));
		if (got.decoded_byte !== want.decoded_byte)
			note_mismatch($sformatf("decoded 0x%02h, want 0x%02h (start %0d)",
				got.decoded_byte, want.decoded_byte, want.token_start));
		if (got.last_token !== want.last_token)
			note_mismatch($sformatf("last %0b, want %0b (tag %0d start %0d)",
				got.last_token, want.last_token, want.token_tag, want.token_start));
	endtask

	// Queue a byte whose tokens come from the predictor.
	task automatic add_row(input logic [7:0] c, input logic eos);
		row_t r;
		r = '0;
		r.it.byte_in = c;
		r.it.end_of_string = eos;
		uri_bytes.push_back(r);
	endtask

	// Queue a byte whose tokens are written out by hand.
	task automatic add_typed(input logic [7:0] c, input logic eos, input int n,
			input utl_pkg::token_t t0, input utl_pkg::token_t t1, input utl_pkg::token_t t2);
		row_t r;
		r.it.byte_in = c;
		r.it.end_of_string = eos;
		r.typed = 1'b1;
		r.n = n[1:0];
		r.toks[0] = t0;
		r.toks[1] = t1;
		r.toks[2] = t2;
		uri_bytes.push_back(r);
	endtask

	function automatic logic [7:0] any_letter();
		return $urandom_range(0, 1) ? 8'(65 + $urandom_range(0, 25)) : 8'(97 + $urandom_range(0, 25));
	endfunction

	// Append one random URI: mostly well-formed pieces, some noise and broken escapes.
	task automatic build_uri();
		int         pieces;
		int         len;
		logic [7:0] c;
		row_t       r;
		string      hexes = "0123456789abcdefABCDEF";
		string      punct = "?=&";
		pieces = $urandom_range(1, 6);
		for (int p = 0; p < pieces; p++) begin
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				len = $urandom_range(1, 6);
				add_row($urandom_range(0, 5) == 0 ? 8'h2e : any_letter(), 1'b0);
				for (int k = 1; k < len; k++) begin
					case ($urandom_range(0, 5))
					0:       add_row(8'(48 + $urandom_range(0, 9)), 1'b0);
					1:       add_row(8'h2e, 1'b0);
					default: add_row(any_letter(), 1'b0);
					endcase
				end
			end
			3: begin
				len = $urandom_range(1, 6);
				add_row(8'h2f, 1'b0);
				for (int k = 1; k < len; k++)
					add_row($urandom_range(0, 3) == 0 ? 8'h2f : any_letter(), 1'b0);
			end
			4: begin
				len = $urandom_range(1, 5);
				for (int k = 0; k < len; k++) add_row(8'(48 + $urandom_range(0, 9)), 1'b0);
			end
			5: begin
				add_row(8'h25, 1'b0);
				add_row(hexes[$urandom_range(0, 21)], 1'b0);
				add_row(hexes[$urandom_range(0, 21)], 1'b0);
			end
			6: add_row(punct[$urandom_range(0, 2)], 1'b0);
			7: begin
				// Break an escape with a non-hex byte after one or two characters.
				add_row(8'h25, 1'b0);
				if ($urandom_range(0, 1)) add_row(hexes[$urandom_range(0, 21)], 1'b0);
				do c = 8'($urandom_range(0, 255)); while (nib(c) >= 0);
				add_row(c, 1'b0);
			end
			8: add_row(8'($urandom_range(0, 255)), 1'b0);
			default: begin
				// Escape fragment: truncated when it lands at the end of the string.
				add_row(8'h25, 1'b0);
				if ($urandom_range(0, 1)) add_row(hexes[$urandom_range(0, 21)], 1'b0);
			end
			endcase
		end
		r = uri_bytes.pop_back();
		r.it.end_of_string = 1'b1;
		uri_bytes.push_back(r);
	endtask

	// Directed rows: punctuation, the byte extremes, every tag, bad and truncated
	// escapes, and both hex cases. Hand-written tokens only where obvious.
	task automatic build_directed();
		add_typed("?", 1'b0, 1, tok(utl_pkg::TAG_QMARK, 0, 1, 0, 0), '0, '0);
		add_typed("=", 1'b0, 1, tok(utl_pkg::TAG_ASSIGN, 1, 1, 0, 0), '0, '0);
		add_typed("&", 1'b0, 1, tok(utl_pkg::TAG_DELIM, 2, 1, 0, 0), '0, '0);
		add_typed(8'h00, 1'b0, 1, tok(utl_pkg::TAG_UNKNOWN, 3, 1, 0, 0), '0, '0);
		add_typed(8'hff, 1'b0, 1, tok(utl_pkg::TAG_UNKNOWN, 4, 1, 0, 0), '0, '0);
		add_row("a", 1'b0);
		add_row("/", 1'b0);
		add_row("1", 1'b0);
		add_row("%", 1'b0);
		add_row("4", 1'b0);
		add_row("F", 1'b0);
		add_row("9", 1'b0);
		add_row("%", 1'b0);
		// non-hex right after the percent: unknown of length 3, then the byte starts a word
		add_typed("g", 1'b0, 1, tok(utl_pkg::TAG_UNKNOWN, 12, 3, 0, 0), '0, '0);
		add_typed(".", 1'b1, 2, tok(utl_pkg::TAG_WORDY, 13, 2, 0, 0),
			tok(utl_pkg::TAG_EOS, 15, 1, 0, 1), '0);
		// string that ends right after the percent
		add_typed("%", 1'b1, 2, tok(utl_pkg::TAG_UNKNOWN, 0, 1, 0, 0),
			tok(utl_pkg::TAG_EOS, 1, 1, 0, 1), '0);
		add_row("%", 1'b0);
		add_row("a", 1'b0);
		// non-hex after the high digit, itself unknown, on the final byte: three tokens
		add_typed("~", 1'b1, 3, tok(utl_pkg::TAG_UNKNOWN, 0, 3, 0, 0),
			tok(utl_pkg::TAG_UNKNOWN, 2, 1, 0, 0), tok(utl_pkg::TAG_EOS, 3, 1, 0, 1));
		add_row("%", 1'b0);
		add_typed("B", 1'b1, 2, tok(utl_pkg::TAG_UNKNOWN, 0, 2, 0, 0),
			tok(utl_pkg::TAG_EOS, 2, 1, 0, 1), '0);
		add_row("5", 1'b1);
		add_row("%", 1'b0);
		add_typed("%", 1'b0, 1, tok(utl_pkg::TAG_UNKNOWN, 0, 3, 0, 0), '0, '0);
		add_row("f", 1'b0);
		add_typed("f", 1'b1, 2, tok(utl_pkg::TAG_ESC, 1, 3, 8'hff, 0),
			tok(utl_pkg::TAG_EOS, 4, 1, 0, 1), '0);
	endtask

	// Sender: reset, then walk the stimulus, predicting tokens as each byte is taken.
	initial begin
		row_t r;
		int   rand_base;
		arst_n = 1'b0;
		push <= 1'b0;
		item <= '0;

		build_directed();
		rand_base = uri_bytes.size();
		while (uri_bytes.size() - rand_base < RANDOM_ITEMS) build_uri();
		hold_at = rand_base + 100;
		pause_at = rand_base + 250;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int idx = 0; idx < uri_bytes.size(); idx++) begin
			r = uri_bytes[idx];
			if (idx >= uri_bytes.size() - CALM_TAIL) calm = 1'b1;
			if (idx == pause_at) begin
				// Drop push and hold until the block owes nothing.
				push <= 1'b0;
				@(posedge clk);
				while (tokens_due.size() != 0) @(posedge clk);
			end else if (!calm && ((idx / 40) % 3) != 0 && $urandom_range(0, 5) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			push <= 1'b1;
			item <= r.it;
			@(posedge clk);
			while (full) @(posedge clk);
			items_taken++;
			predict_tokens(r.it.byte_in, r.it.end_of_string);
			if (r.typed) begin
				for (int k = 0; k < r.n; k++) tokens_due.push_back(r.toks[k]);
			end else begin
				foreach (fresh_tokens[k]) tokens_due.push_back(fresh_tokens[k]);
			end
		end
		push <= 1'b0;

		// Drain, then give the block a few cycles to show any stray token.
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver: check every popped token; stall in random bursts and once for a
	// long stretch so the token queue fills and full rises.
	initial begin
		int rx_cycles;
		int hold_left;
		bit hold_done;
		rx_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		pop <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (pop && !empty) check_token(result);
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && items_taken >= hold_at) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				pop <= 1'b0;
			end else if (!calm && ((rx_cycles / 150) % 3) != 0 && $urandom_range(0, 6) == 0) begin
				hold_left = $urandom_range(1, 15) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if neither side moves a request for too long.
	always @(posedge clk) begin
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((push && !full) || (pop && !empty)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no progress for %0d cycles", $time, quiet);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

### uri_token_lexer.f
sv/utl_pkg.sv
sv/utl_front.sv
sv/utl_queue.sv
sv/utl_back.sv
sv/uri_token_lexer.sv
sv/utl_checker.sv
tb/sv/tb_uri_token_lexer.sv
